@@ sv/ir_psr_pkg.sv @@
// Shared types and constants for the IR pulse/space recorder.
// Used by the front, back and top-level modules.

package ir_psr_pkg;

    localparam int DUR_W    = 24;
    localparam int MERGE_W  = 25;
    localparam int LEVEL_W  = 9;
    localparam int SEC_W    = 32;
    localparam int USEC_W   = 20;
    localparam int TMO_W    = 8;
    localparam int PROD_W   = 28;   // 255 * 1000000 fits
    localparam int CFG_W    = 24;
    localparam int CFG_IDX_W = 2;

    localparam logic [DUR_W-1:0]   DUR_MAX           = 24'hFF_FFFF;
    localparam logic [LEVEL_W-1:0] HIGH_THRESHOLD    = 9'd128;
    localparam logic [USEC_W-1:0]  MICROS_PER_SECOND = 20'd1000000;

    localparam logic              RST_ACTIVE_LOW  = 1'b1;
    localparam logic [DUR_W-1:0]  RST_GLITCH_LIM  = 24'd250;
    localparam logic [DUR_W-1:0]  RST_LONG_SPACE  = 24'd20000;
    localparam logic [TMO_W-1:0]  RST_TIMEOUT_SEC = 8'd15;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ACTIVE_LOW  = 2'd0,
        REG_GLITCH_LIM  = 2'd1,
        REG_LONG_SPACE  = 2'd2,
        REG_TIMEOUT_SEC = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [DUR_W-1:0] glitch_lim;
        logic [DUR_W-1:0] long_space;
        logic [TMO_W-1:0] timeout_sec;
    } t_cfg;

    typedef struct packed {
        logic load;
        logic value;
    } t_sense_load;

    // One classified edge between front and back
    typedef struct packed {
        logic [DUR_W-1:0] dur;
        logic             pulse;
    } t_edge;

    // One output word
    typedef struct packed {
        logic [DUR_W-1:0] dur;
        logic             pulse;
        logic             last;
    } t_word;

    function automatic logic [DUR_W-1:0] sat_dur(input logic [MERGE_W-1:0] x);
        sat_dur = x[MERGE_W-1] ? DUR_MAX : x[DUR_W-1:0];
    endfunction

endpackage

@@ sv/ir_psr_fifo.sv @@
// Small register queue between front and back of the IR recorder.
// Depends on nothing; width and depth come from parameters.

module ir_psr_fifo #(
    parameter int WIDTH = 25,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_ready,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data,
    input  logic             i_pop
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             do_push, do_pop;

    assign o_ready = (r_cnt != CNT_W'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (do_pop) begin
            n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

@@ sv/ir_psr_front.sv @@
// Front of the IR recorder: takes edges, measures the gap, tracks sense.
// Registered compare/subtract and multiply, then combinational add/clamp/classify. Uses ir_psr_pkg.

module ir_psr_front
    import ir_psr_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [LEVEL_W-1:0] i_level,
    input  logic [SEC_W-1:0]   i_sec,
    input  logic [USEC_W-1:0]  i_usec,
    input  logic [TMO_W-1:0]   i_timeout_sec,
    input  t_sense_load        i_sense_load,
    output logic               o_push,
    output t_edge              o_edge,
    input  logic               i_q_ready
);
    localparam int UD_W = USEC_W + 1;
    localparam int SUM_W = PROD_W + 2;

    logic [SEC_W-1:0]  r_prev_sec;
    logic [USEC_W-1:0] r_prev_usec;
    logic              r_sense, n_sense;

    // stage 1
    logic              r1_v;
    logic              r1_level, r1_bwd, r1_long;
    logic [TMO_W-1:0]  r1_sd;
    logic [UD_W-1:0]   r1_ud;
    // stage 2
    logic              r2_v;
    logic              r2_level, r2_bwd, r2_long;
    logic [PROD_W-1:0] r2_prod;
    logic [UD_W-1:0]   r2_ud;

    logic              acc, adv2;
    logic              bwd, long_gap;
    logic [SEC_W-1:0]  sdiff;
    logic signed [SUM_W-1:0] gap;
    logic [DUR_W-1:0]  dur;

    assign o_ready = !r1_v || !r2_v || i_q_ready;
    assign acc     = i_valid && o_ready;
    assign adv2    = r1_v && (!r2_v || i_q_ready);
    assign o_push  = r2_v;

    assign sdiff    = i_sec - r_prev_sec;
    assign bwd      = (i_sec < r_prev_sec) || (i_sec == r_prev_sec && i_usec < r_prev_usec);
    assign long_gap = !bwd && (sdiff > {{(SEC_W-TMO_W){1'b0}}, i_timeout_sec});

    always_comb begin
        gap = $signed({2'b00, r2_prod}) + $signed({{(SUM_W-UD_W){r2_ud[UD_W-1]}}, r2_ud});
        if (r2_bwd || r2_long) begin
            dur = DUR_MAX;
        end else if (gap < 0) begin
            dur = '0;
        end else if (gap > $signed({{(SUM_W-DUR_W){1'b0}}, DUR_MAX})) begin
            dur = DUR_MAX;
        end else begin
            dur = gap[DUR_W-1:0];
        end
        // long gap on the active level: flip sense so it reads as a space
        n_sense = (r2_long && (r2_level == r_sense)) ? ~r_sense : r_sense;
        o_edge.dur   = dur;
        o_edge.pulse = (r2_level == n_sense);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_sec  <= '0;
            r_prev_usec <= '0;
            r_sense     <= RST_ACTIVE_LOW;
            r1_v        <= 1'b0;
            r2_v        <= 1'b0;
        end else begin
            if (acc) begin
                r_prev_sec  <= i_sec;
                r_prev_usec <= i_usec;
            end
            if (i_sense_load.load) begin
                r_sense <= i_sense_load.value;
            end else if (r2_v && i_q_ready) begin
                r_sense <= n_sense;
            end
            if (acc) begin
                r1_v <= 1'b1;
            end else if (adv2) begin
                r1_v <= 1'b0;
            end
            if (adv2) begin
                r2_v <= 1'b1;
            end else if (i_q_ready) begin
                r2_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r1_level <= (i_level > HIGH_THRESHOLD);
            r1_bwd   <= bwd;
            r1_long  <= long_gap;
            r1_sd    <= sdiff[TMO_W-1:0];
            r1_ud    <= {1'b0, i_usec} - {1'b0, r_prev_usec};
        end
        if (adv2) begin
            r2_level <= r1_level;
            r2_bwd   <= r1_bwd;
            r2_long  <= r1_long;
            r2_prod  <= PROD_W'(r1_sd) * PROD_W'(MICROS_PER_SECOND);
            r2_ud    <= r1_ud;
        end
    end

endmodule

@@ sv/ir_psr_back.sv @@
// Back of the IR recorder: glitch filter and word emitter.
// Pops classified edges, holds long spaces, sends zero to three words. Uses ir_psr_pkg.

module ir_psr_back
    import ir_psr_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_cfg  i_cfg,
    input  logic  i_q_valid,
    input  t_edge i_edge,
    output logic  o_pop,
    output logic  o_valid,
    input  logic  i_ready,
    output t_word o_word
);
    localparam int SLOTS = 3;
    localparam int CNT_W = 2;

    logic                r_held, n_held;
    logic [DUR_W-1:0]    r_held_len, n_held_len;
    logic [MERGE_W-1:0]  r_merged, n_merged;
    t_word               r_slot [SLOTS];
    t_word               n_set  [SLOTS];
    logic [CNT_W-1:0]    r_cnt, n_num;

    logic                take;
    logic [MERGE_W-1:0]  msum;
    logic [DUR_W-1:0]    mp_sat, acc1;
    logic                long_sp;

    assign take    = o_valid && i_ready;
    assign o_valid = (r_cnt != '0);
    assign o_word  = r_slot[0];
    assign o_pop   = i_q_valid && ((r_cnt == '0) || (r_cnt == CNT_W'(1) && take));

    always_comb begin
        msum    = r_merged + {1'b0, i_edge.dur};
        mp_sat  = sat_dur(r_merged);
        acc1    = sat_dur({1'b0, r_held_len} + {1'b0, mp_sat});
        long_sp = (i_edge.dur > i_cfg.long_space);
        n_held     = r_held;
        n_held_len = r_held_len;
        n_merged   = r_merged;
        n_num      = '0;
        for (int k = 0; k < SLOTS; k++) begin
            n_set[k] = '0;
        end
        if (i_edge.pulse) begin
            if (r_held) begin
                n_merged = msum;
                if (msum > {1'b0, i_cfg.glitch_lim}) begin
                    n_set[0] = '{dur: r_held_len,    pulse: 1'b0, last: 1'b0};
                    n_set[1] = '{dur: sat_dur(msum), pulse: 1'b1, last: 1'b1};
                    n_num    = CNT_W'(2);
                    n_held   = 1'b0;
                    n_merged = '0;
                end
            end else begin
                n_set[0] = '{dur: i_edge.dur, pulse: 1'b1, last: 1'b1};
                n_num    = CNT_W'(1);
            end
        end else if (!r_held) begin
            if (long_sp) begin
                n_held_len = i_edge.dur;
                n_held     = 1'b1;
            end else begin
                n_set[0] = '{dur: i_edge.dur, pulse: 1'b0, last: 1'b1};
                n_num    = CNT_W'(1);
            end
        end else if (long_sp) begin
            // fold the glitch pulses and the new space into the held space
            n_held_len = sat_dur({1'b0, acc1} + {1'b0, i_edge.dur});
            n_merged   = '0;
        end else begin
            n_set[0] = '{dur: r_held_len, pulse: 1'b0, last: 1'b0};
            n_set[1] = '{dur: mp_sat,     pulse: 1'b1, last: 1'b0};
            n_set[2] = '{dur: i_edge.dur, pulse: 1'b0, last: 1'b1};
            n_num    = CNT_W'(3);
            n_held   = 1'b0;
            n_merged = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held     <= 1'b0;
            r_held_len <= '0;
            r_merged   <= '0;
            r_cnt      <= '0;
        end else if (o_pop) begin
            r_held     <= n_held;
            r_held_len <= n_held_len;
            r_merged   <= n_merged;
            r_cnt      <= n_num;
        end else if (take) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            for (int k = 0; k < SLOTS; k++) begin
                r_slot[k] <= n_set[k];
            end
        end else if (take) begin
            // advance to the next word of this edge
            for (int k = 0; k < SLOTS - 1; k++) begin
                r_slot[k] <= r_slot[k+1];
            end
        end
    end

endmodule

@@ sv/ir_pulse_space_recorder.sv @@
// IR pulse/space recorder: takes one receiver edge per item (level sample and
// seconds/microseconds stamp) and emits mode2-style pulse/space words, with long
// spaces held and short glitch pulses folded into them. An edge enters every cycle
// while the four-entry edge queue has room; the front registers it after compare and
// subtract and after the 8 x 20 bit multiply, then adds and clamps before queueing.
// The back retires one queued edge per cycle when it yields at most one word and
// the output does not stall; an edge yielding more words is retired when its last
// word is taken on the single output port. Configuration writes apply on the next
// cycle; writing the polarity register also reloads the current sense.
// Uses ir_psr_pkg, ir_psr_front, ir_psr_fifo and ir_psr_back.

module ir_pulse_space_recorder
    import ir_psr_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // config write port
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    // input edges
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [63:0]          s_axis_tdata,  // [8:0] level_sample, [40:9] stamp_seconds,
                                                // [60:41] stamp_micros, [63:61] zero
    // output words
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [23:0]          m_axis_tdata,  // [23:0] duration_us
    output logic                 m_axis_tuser,  // [0] is_pulse
    output logic                 m_axis_tlast   // last_word
);
    localparam int EDGE_W = $bits(t_edge);

    t_cfg        r_cfg;
    t_sense_load sense_load;
    logic        q_push, q_ready, q_valid, q_pop;
    t_edge       f_edge, q_edge;
    t_word       word;

    assign sense_load.load  = i_cfg_we && (i_cfg_idx == REG_ACTIVE_LOW);
    assign sense_load.value = i_cfg_data[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.glitch_lim  <= RST_GLITCH_LIM;
            r_cfg.long_space  <= RST_LONG_SPACE;
            r_cfg.timeout_sec <= RST_TIMEOUT_SEC;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                // polarity goes straight into the front's sense
                REG_ACTIVE_LOW:  ;
                REG_GLITCH_LIM:  r_cfg.glitch_lim  <= i_cfg_data[DUR_W-1:0];
                REG_LONG_SPACE:  r_cfg.long_space  <= i_cfg_data[DUR_W-1:0];
                REG_TIMEOUT_SEC: r_cfg.timeout_sec <= i_cfg_data[TMO_W-1:0];
                default: ;
            endcase
        end
    end

    ir_psr_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (s_axis_tvalid),
        .o_ready       (s_axis_tready),
        .i_level       (s_axis_tdata[8:0]),
        .i_sec         (s_axis_tdata[40:9]),
        .i_usec        (s_axis_tdata[60:41]),
        .i_timeout_sec (r_cfg.timeout_sec),
        .i_sense_load  (sense_load),
        .o_push        (q_push),
        .o_edge        (f_edge),
        .i_q_ready     (q_ready)
    );

    ir_psr_fifo #(
        .WIDTH (EDGE_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (f_edge),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_data  (q_edge),
        .i_pop   (q_pop)
    );

    ir_psr_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_valid (q_valid),
        .i_edge    (q_edge),
        .o_pop     (q_pop),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_word    (word)
    );

    assign m_axis_tdata = word.dur;
    assign m_axis_tuser = word.pulse;
    assign m_axis_tlast = word.last;

endmodule

@@ tb/ir_pulse_space_recorder_test.sv @@
`timescale 1ns / 100ps
// Self-checking bench for ir_pulse_space_recorder: edges go in on the input stream and the
// output words are scored against an in-bench pulse/space filter model.
// Depends on ir_psr_pkg and the recorder RTL only.

module ir_pulse_space_recorder_test;
    import ir_psr_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam int SETTLE_CYCLES = 20;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [63:0]          s_axis_tdata;  // [8:0] level_sample, [40:9] stamp_seconds,
                                         // [60:41] stamp_micros, [63:61] zero
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [23:0]          m_axis_tdata;  // [23:0] duration_us
    logic                 m_axis_tuser;  // [0] is_pulse
    logic                 m_axis_tlast;

    ir_pulse_space_recorder i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #1 i_clk = ~i_clk;

    // register copies
    logic               cfg_act_low;
    logic [DUR_W-1:0]   cfg_glitch;
    logic [DUR_W-1:0]   cfg_long;
    logic [TMO_W-1:0]   cfg_tmo;
    // filter state
    logic [SEC_W-1:0]   last_sec;
    logic [USEC_W-1:0]  last_usec;
    logic               sense_bit;
    logic               hold_on;
    logic [DUR_W-1:0]   hold_len;
    logic [MERGE_W-1:0] merge_len;

    logic [63:0] edges_to_send[$];
    t_word       pending_words[$];

    logic edge_taken = 1'b0;
    logic word_taken = 1'b0;
    bit   idle_on = 1'b1;
    int   send_wait = 0;
    int   sink_wait = 0;
    int   cycles = 0;
    int   edges_in = 0;
    int   words_out = 0;
    int   mismatches = 0;
    int   settings = 1;

    // stimulus timeline
    logic [SEC_W-1:0] g_sec;
    int               g_usec;
    bit               line_hi;

    function automatic logic [DUR_W-1:0] sat24(input logic [MERGE_W-1:0] x);
        return (x > {1'b0, DUR_MAX}) ? DUR_MAX : x[DUR_W-1:0];
    endfunction

    function automatic int draw_wait();
        return idle_on ? $urandom_range(0, 10) : 0;
    endfunction

    task automatic classify_edge(input logic [LEVEL_W-1:0] smp, input logic [SEC_W-1:0] sec,
                                 input logic [USEC_W-1:0] usec);
        logic             lvl;
        logic             pulse;
        logic [DUR_W-1:0] dur;
        longint           span;
        longint           dsec;
        logic [DUR_W-1:0] wd[3];
        logic             wp[3];
        int               n;
        t_word            w;
        n = 0;
        lvl = (smp > HIGH_THRESHOLD);
        if (sec < last_sec || (sec == last_sec && usec < last_usec)) begin
            dur = DUR_MAX;
        end else if (sec - last_sec > {24'd0, cfg_tmo}) begin
            dur = DUR_MAX;
            // a long gap whose level says carrier-on means the polarity was wrong
            if (lvl == sense_bit) sense_bit = ~sense_bit;
        end else begin
            dsec = sec - last_sec;
            span = dsec * 1000000 + longint'(usec) - longint'(last_usec);
            if (span < 0) span = 0;
            dur = (span > longint'(DUR_MAX)) ? DUR_MAX : span[DUR_W-1:0];
        end
        last_sec = sec;
        last_usec = usec;
        pulse = (lvl == sense_bit);

        if (pulse) begin
            if (hold_on) begin
                merge_len = merge_len + {1'b0, dur};
                if (merge_len > {1'b0, cfg_glitch}) begin
                    wd[0] = hold_len;          wp[0] = 1'b0;
                    wd[1] = sat24(merge_len);  wp[1] = 1'b1;
                    n = 2;
                    hold_on = 1'b0;
                    merge_len = '0;
                end
            end else begin
                wd[0] = dur; wp[0] = 1'b1; n = 1;
            end
        end else if (!hold_on) begin
            if (dur > cfg_long) begin
                hold_len = dur;
                hold_on = 1'b1;
            end else begin
                wd[0] = dur; wp[0] = 1'b0; n = 1;
            end
        end else if (dur > cfg_long) begin
            // fold merged pulse and new space into the held space
            hold_len = sat24({1'b0, hold_len} + {1'b0, sat24(merge_len)});
            hold_len = sat24({1'b0, hold_len} + {1'b0, dur});
            merge_len = '0;
        end else begin
            wd[0] = hold_len;         wp[0] = 1'b0;
            wd[1] = sat24(merge_len); wp[1] = 1'b1;
            wd[2] = dur;              wp[2] = 1'b0;
            n = 3;
            hold_on = 1'b0;
            merge_len = '0;
        end

        for (int k = 0; k < n; k++) begin
            w.dur = wd[k];
            w.pulse = wp[k];
            w.last = (k == n - 1);
            pending_words.push_back(w);
        end
    endtask

    // acceptance, prediction and scoring
    always @(posedge i_clk) begin
        edge_taken <= i_rst_n && s_axis_tvalid && s_axis_tready;
        word_taken <= i_rst_n && (m_axis_tvalid === 1'b1) && m_axis_tready;
        if (i_rst_n && (m_axis_tvalid === 1'b1) && m_axis_tready) begin
            words_out++;
            if (pending_words.size() == 0) begin
                if (mismatches < 10)
                    $display("word %0d: none expected, got dur %h pulse %b last %b",
                             words_out, m_axis_tdata, m_axis_tuser, m_axis_tlast);
                mismatches++;
            end else begin
                t_word w;
                w = pending_words.pop_front();
                if (m_axis_tdata !== w.dur || m_axis_tuser !== w.pulse
                        || m_axis_tlast !== w.last) begin
                    if (mismatches < 10)
                        $display("word %0d: exp dur %h pulse %b last %b, got %h %b %b",
                                 words_out, w.dur, w.pulse, w.last,
                                 m_axis_tdata, m_axis_tuser, m_axis_tlast);
                    mismatches++;
                end
            end
        end
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            edges_in++;
            classify_edge(s_axis_tdata[8:0], s_axis_tdata[40:9], s_axis_tdata[60:41]);
        end
    end

    // edge sender
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || edge_taken) begin
            if (send_wait > 0) begin
                send_wait--;
                s_axis_tvalid <= 1'b0;
            end else if (edges_to_send.size() > 0) begin
                s_axis_tdata <= edges_to_send.pop_front();
                s_axis_tvalid <= 1'b1;
                send_wait = draw_wait();
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // word receiver back-pressure
    always @(negedge i_clk) begin
        if (word_taken) sink_wait = draw_wait();
        if (sink_wait > 0) begin
            sink_wait--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= i_rst_n;
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words outstanding",
                     cycles, pending_words.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic write_reg(input t_reg_idx idx, input logic [CFG_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_ACTIVE_LOW: begin
                cfg_act_low = val[0];
                sense_bit = val[0];
            end
            REG_GLITCH_LIM:  cfg_glitch = val[DUR_W-1:0];
            REG_LONG_SPACE:  cfg_long = val[DUR_W-1:0];
            REG_TIMEOUT_SEC: cfg_tmo = val[TMO_W-1:0];
            default: ;
        endcase
    endtask

    task automatic write_all(input logic act_low, input logic [DUR_W-1:0] glitch,
                             input logic [DUR_W-1:0] long_lim, input logic [TMO_W-1:0] tmo);
        write_reg(REG_ACTIVE_LOW, {23'd0, act_low});
        write_reg(REG_GLITCH_LIM, glitch);
        write_reg(REG_LONG_SPACE, long_lim);
        write_reg(REG_TIMEOUT_SEC, {16'd0, tmo});
        settings++;
    endtask

    // hold until every queued edge is taken and every expected word is back
    task automatic drain();
        do @(posedge i_clk); while (edges_to_send.size() != 0 || s_axis_tvalid);
        while (pending_words.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic edge_at(input logic [LEVEL_W-1:0] smp, input logic [SEC_W-1:0] sec,
                           input logic [USEC_W-1:0] usec);
        g_sec = sec;
        g_usec = usec;
        edges_to_send.push_back({3'b000, usec, sec, smp});
    endtask

    task automatic advance_us(input int d);
        longint total;
        total = longint'(g_usec) + d;
        g_sec = g_sec + SEC_W'(total / 1000000);
        g_usec = int'(total % 1000000);
    endtask

    task automatic make_edge(input bit hi);
        int               roll;
        logic [LEVEL_W-1:0] smp;
        logic [USEC_W-1:0]  us;
        roll = $urandom_range(0, 99);
        if (roll < 40) begin
            advance_us($urandom_range(1, 3000));
        end else if (roll < 60) begin
            advance_us($urandom_range(0, 300));
        end else if (roll < 80) begin
            if (cfg_long < 24'hF0_0000)
                advance_us(int'(cfg_long) + 1 + $urandom_range(0, 50000));
            else
                advance_us($urandom_range(1, 3000));
        end else if (roll < 88) begin
            g_sec = g_sec + cfg_tmo + 1 + $urandom_range(0, 300);
        end else if (roll < 93) begin
            if (g_usec > 0 && $urandom_range(0, 1))
                g_usec = $urandom_range(0, g_usec - 1);
            else
                g_sec = g_sec - $urandom_range(1, 1000);
        end else if (roll < 96) begin
            // same stamp again: zero length
        end else if (roll < 98) begin
            g_usec = $urandom_range(1000000, 1048575);
        end else begin
            if (cfg_tmo > 0) g_sec = g_sec + $urandom_range(1, cfg_tmo);
            g_usec = $urandom_range(0, 999999);
        end
        smp = hi ? LEVEL_W'($urandom_range(129, 511)) : LEVEL_W'($urandom_range(0, 128));
        us = g_usec[USEC_W-1:0];
        edges_to_send.push_back({3'b000, us, g_sec, smp});
    endtask

    task automatic run_random(input int count, input bit pause_midway);
        g_sec = $urandom();
        g_usec = $urandom_range(0, 999999);
        for (int k = 0; k < count; k++) begin
            if (pause_midway && k == count / 2) drain();
            // mostly alternate the line, sometimes repeat a level
            if ($urandom_range(0, 9) != 0) line_hi = !line_hi;
            make_edge(line_hi);
        end
        drain();
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        line_hi = 1'b0;
        cfg_act_low = RST_ACTIVE_LOW;
        cfg_glitch = RST_GLITCH_LIM;
        cfg_long = RST_LONG_SPACE;
        cfg_tmo = RST_TIMEOUT_SEC;
        last_sec = '0;
        last_usec = '0;
        sense_bit = RST_ACTIVE_LOW;
        hold_on = 1'b0;
        hold_len = '0;
        merge_len = '0;

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed edges under reset settings
        edge_at(9'd0,   32'd0, 20'd0);        // zero length space
        edge_at(9'd129, 32'd0, 20'd100);      // just above threshold
        edge_at(9'd128, 32'd0, 20'd600);      // threshold itself is low
        edge_at(9'd511, 32'd0, 20'd700);
        edge_at(9'd0,   32'd0, 20'd30700);    // long space gets held
        edge_at(9'd200, 32'd0, 20'd30800);    // glitch pulses fold in
        edge_at(9'd300, 32'd0, 20'd30900);
        edge_at(9'd50,  32'd0, 20'd31000);    // short space flushes three words
        edge_at(9'd10,  32'd0, 20'd81000);
        edge_at(9'd400, 32'd0, 20'd81100);
        edge_at(9'd5,   32'd0, 20'd141100);   // long space merges into held one
        edge_at(9'd300, 32'd0, 20'd141500);   // pulse over the glitch limit flushes
        edge_at(9'd0,   32'd0, 20'd100);      // clock went backward
        edge_at(9'd300, 32'd20, 20'd5);       // timeout with carrier level flips sense
        edge_at(9'd0,   32'd20, 20'hF_FFFF);  // micros beyond one second
        edge_at(9'd200, 32'd21, 20'd0);       // negative difference clamps to zero
        edge_at(9'd511, 32'd36, 20'd999999);  // gap right at the timeout
        edge_at(9'd0,   32'hFFFF_FFF0, 20'd524287);
        edge_at(9'd300, 32'hFFFF_FFFF, 20'd999999);
        edge_at(9'd0,   32'hFFFF_FFFF, 20'd999999);
        edge_at(9'd129, 32'hFFFF_FFFF, 20'd0);
        drain();

        idle_on = 1'b1;
        write_all(1'b0, 24'd0, DUR_MAX, 8'd0);
        run_random(70, 1'b0);

        write_all(1'b1, DUR_MAX, 24'd0, 8'd255);
        // saturate the merged pulse and the held space
        edge_at(9'd0,   32'd1000, 20'd0);
        edge_at(9'd300, 32'd999, 20'd0);
        edge_at(9'd300, 32'd998, 20'd0);
        edge_at(9'd0,   32'd997, 20'd0);
        edge_at(9'd0,   32'd996, 20'd0);
        run_random(70, 1'b1);

        idle_on = 1'b0;
        write_all(1'b0, 24'($urandom_range(100, 1000)), 24'($urandom_range(2000, 30000)),
                  8'($urandom_range(1, 20)));
        run_random(80, 1'b0);

        idle_on = 1'b1;
        for (int p = 0; p < 3; p++) begin
            write_all(1'($urandom_range(0, 1)), 24'($urandom_range(0, 2000)),
                      24'($urandom_range(0, 60000)), 8'($urandom_range(0, 40)));
            run_random(80, 1'b0);
        end

        if (pending_words.size() != 0) mismatches++;
        $display("%0d edges driven and %0d words scored across %0d register settings",
                 edges_in, words_out, settings);
        $display("%0d mismatches", mismatches);
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

@@ ir_pulse_space_recorder.f @@
sv/ir_psr_pkg.sv
sv/ir_psr_fifo.sv
sv/ir_psr_front.sv
sv/ir_psr_back.sv
sv/ir_pulse_space_recorder.sv
tb/ir_pulse_space_recorder_test.sv
